[design/multi_axis_slice_step_quantizer_defines.svh]
// ============================================================================
// Assertion macros for the multi-axis slice step quantizer
// Shared concurrent assertion forms, with and without a reset qualifier.
// ============================================================================
`ifndef MULTI_AXIS_SLICE_STEP_QUANTIZER_DEFINES_SVH
`define MULTI_AXIS_SLICE_STEP_QUANTIZER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MASSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MASSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/massq_pkg.sv]
// ============================================================================
// massq_pkg
// Types and constants shared by the slice step quantizer modules.
// ============================================================================
package massq_pkg;

    // Axis count and index widths.
    localparam int NUM_AXES   = 3;
    localparam int AXIS_IDX_W = 2;
    localparam int AXIS_ID_W  = 2;

    // Field widths.
    localparam int DIST_W   = 16;
    localparam int SCALE_W  = 28;
    localparam int SLICE_W  = 40;
    localparam int STEP_W   = 20;
    localparam int PERIOD_W = 32;
    localparam int POS_W    = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Rounding datapath. Slice values are shifted up by TIME_SHIFT so that
    // both axis and slice values round at SCALE_FRAC fraction bits.
    localparam int SCALE_FRAC = 24;
    localparam int TIME_SHIFT = 8;
    localparam int PROD_W     = 45;
    localparam int V_W        = 50;
    localparam int Q_W        = V_W - SCALE_FRAC;
    localparam int RES_W      = 26;
    localparam int TRES_W     = 18;
    localparam int CYC_W      = Q_W;
    localparam int GAP_W      = 32;
    localparam int TOTAL_W    = GAP_W + 1;

    // Serial divider.
    localparam int DIV_STEPS = TOTAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Reset values and special indexes.
    localparam logic [SCALE_W-1:0]    SCALE_RESET   = 28'd16777216;
    localparam logic [SLICE_W-1:0]    SLICE_RESET   = 40'd8192000000;
    localparam logic [CFG_IDX_W-1:0]  CFG_SLICE_IDX = CFG_IDX_W'(NUM_AXES);
    localparam logic [AXIS_IDX_W-1:0] LAST_IDX      = AXIS_IDX_W'(NUM_AXES - 1);
    localparam logic [AXIS_ID_W-1:0]  LAST_AXIS_ID  = AXIS_ID_W'(NUM_AXES - 1);

    // Input item: one signed move per axis.
    typedef struct packed {
        logic signed [DIST_W-1:0] dist_axis0;
        logic signed [DIST_W-1:0] dist_axis1;
        logic signed [DIST_W-1:0] dist_axis2;
    } t_in_item;

    // Result item: one per axis.
    typedef struct packed {
        logic [AXIS_ID_W-1:0]    axis_id;
        logic [STEP_W-1:0]       step_count;
        logic                    direction;
        logic [PERIOD_W-1:0]     step_period;
        logic signed [POS_W-1:0] position;
        logic                    last_axis;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ADD,
        ST_ABS,
        ST_QUOT,
        ST_SIGN,
        ST_COMMIT,
        ST_DIV_START,
        ST_DIV_STEP,
        ST_GAP,
        ST_EMIT
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LOAD,
        OP_ADD,
        OP_ABS,
        OP_QUOT,
        OP_SIGN,
        OP_COMMIT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_GAP,
        OP_EMIT
    } t_dp_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_dp_op                op;
        logic [AXIS_IDX_W-1:0] idx;
        logic                  time_sel;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic any_step;
        logic out_free;
    } t_dp_status;

endpackage

[design/massq_ctrl.sv]
// ============================================================================
// massq_ctrl
// Sequencer that walks each axis and the slice length through the shared
// rounding steps, then divides and emits one result per axis or grows the gap.
// ============================================================================
module massq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  massq_pkg::t_dp_status  i_status,
    output massq_pkg::t_dp_cmd     o_cmd
);
    import massq_pkg::*;

    t_state                r_state, n_state;
    logic [AXIS_IDX_W-1:0] r_idx, n_idx;
    logic                  r_time, n_time;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_time  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_time  <= n_time;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_time         = r_time;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_cmd.op       = OP_NOP;
        o_cmd.idx      = r_idx;
        o_cmd.time_sel = r_time;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_idx    = '0;
                    n_time   = 1'b0;
                    n_state  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = ST_ABS;
            end
            ST_ABS: begin
                o_cmd.op = OP_ABS;
                n_state  = ST_QUOT;
            end
            ST_QUOT: begin
                o_cmd.op = OP_QUOT;
                n_state  = ST_SIGN;
            end
            ST_SIGN: begin
                o_cmd.op = OP_SIGN;
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                if (r_time) begin
                    n_state = i_status.any_step ? ST_DIV_START : ST_GAP;
                end else if (r_idx == LAST_IDX) begin
                    n_time  = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_idx   = r_idx + AXIS_IDX_W'(1);
                    n_state = ST_LOAD;
                end
            end
            ST_DIV_START: begin
                o_cmd.op = OP_DIV_START;
                n_cnt    = '0;
                n_state  = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end
            end
            ST_GAP: begin
                o_cmd.op = OP_GAP;
                n_state  = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + AXIS_IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/massq_dp.sv]
// ============================================================================
// massq_dp
// Datapath: configuration registers, step scaling, shared round-to-nearest
// unit, residual and position state, gap counter, per-axis serial dividers
// and the output register.
// ============================================================================
module massq_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  massq_pkg::t_dp_cmd                i_cmd,
    output massq_pkg::t_dp_status             o_status,
    input  massq_pkg::t_in_item               i_in,
    input  logic                              i_cfg_valid,
    input  logic [massq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [massq_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output massq_pkg::t_out_item              o_out
);
    import massq_pkg::*;

    localparam logic [V_W-1:0] HALF = V_W'(1) << (SCALE_FRAC - 1);

    // Configuration.
    logic [SCALE_W-1:0]        r_scale [NUM_AXES];
    logic [SLICE_W-1:0]        r_slice;

    // Per-item and carried state.
    logic signed [DIST_W-1:0]  r_dist  [NUM_AXES];
    logic signed [RES_W-1:0]   r_res   [NUM_AXES];
    logic signed [POS_W-1:0]   r_pos   [NUM_AXES];
    logic [STEP_W-1:0]         r_steps [NUM_AXES];
    logic                      r_dir   [NUM_AXES];
    logic signed [TRES_W-1:0]  r_time_res;
    logic [GAP_W-1:0]          r_gap;
    logic [CYC_W-1:0]          r_cycles;
    logic                      r_any;

    // Rounding unit.
    logic signed [V_W-1:0]     r_v;
    logic [V_W-1:0]            r_mag;
    logic                      r_neg;
    logic [Q_W-1:0]            r_q;
    logic signed [Q_W-1:0]     r_s;

    // Dividers, one lane per axis.
    logic [TOTAL_W-1:0]        r_dq    [NUM_AXES];
    logic [STEP_W-1:0]         r_rem   [NUM_AXES];

    // Output register.
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic signed [PROD_W-1:0]  w_prod;
    logic signed [V_W-1:0]     w_addend;
    logic [V_W-1:0]            w_sum_q;
    logic signed [V_W-1:0]     w_res;
    logic                      w_zero;
    logic [GAP_W:0]            w_gap_sum;
    logic [TOTAL_W-1:0]        w_total;
    logic [PERIOD_W-1:0]       w_period;

    // Scaled move of the selected axis.
    assign w_prod = $signed(r_dist[i_cmd.idx]) * $signed({1'b0, r_scale[i_cmd.idx]});

    // Carried residual of the selected target, aligned to the rounding point.
    assign w_addend = i_cmd.time_sel ?
        {{(V_W - TRES_W - TIME_SHIFT){r_time_res[TRES_W-1]}}, r_time_res,
         {TIME_SHIFT{1'b0}}} :
        {{(V_W - RES_W){r_res[i_cmd.idx][RES_W-1]}}, r_res[i_cmd.idx]};

    // Rounding and residual arithmetic.
    assign w_sum_q = r_mag + HALF;
    assign w_res   = r_v - {r_s, {SCALE_FRAC{1'b0}}};
    assign w_zero  = (r_dist[i_cmd.idx] == '0);

    // Gap accumulation and total cycles for the dividers.
    assign w_gap_sum = {1'b0, r_gap} + (GAP_W + 1)'(r_cycles);
    assign w_total   = TOTAL_W'(r_cycles) + {1'b0, r_gap};

    // Period of the selected axis, saturated, zero when the axis is idle.
    always_comb begin
        if (r_steps[i_cmd.idx] == '0) begin
            w_period = '0;
        end else if (r_dq[i_cmd.idx][TOTAL_W-1]) begin
            w_period = '1;
        end else begin
            w_period = r_dq[i_cmd.idx][PERIOD_W-1:0];
        end
    end

    // Configuration registers and carried state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_scale[a] <= SCALE_RESET;
                r_res[a]   <= '0;
                r_pos[a]   <= '0;
            end
            r_slice    <= SLICE_RESET;
            r_time_res <= '0;
            r_gap      <= '0;
            r_any      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (i_cfg_index == CFG_IDX_W'(a)) begin
                        r_scale[a] <= i_cfg_data[SCALE_W-1:0];
                    end
                end
                if (i_cfg_index == CFG_SLICE_IDX) begin
                    r_slice <= i_cfg_data[SLICE_W-1:0];
                end
            end
            case (i_cmd.op)
                OP_CAPTURE: begin
                    r_any <= 1'b0;
                end
                OP_COMMIT: begin
                    if (i_cmd.time_sel) begin
                        r_time_res <= w_res[TIME_SHIFT+TRES_W-1:TIME_SHIFT];
                    end else if (!w_zero) begin
                        // A zero move keeps its residual and position.
                        r_res[i_cmd.idx] <= w_res[RES_W-1:0];
                        r_pos[i_cmd.idx] <= r_pos[i_cmd.idx] +
                            {{(POS_W - Q_W){r_s[Q_W-1]}}, r_s};
                        if (r_q != '0) begin
                            r_any <= 1'b1;
                        end
                    end
                end
                OP_DIV_START: begin
                    r_gap <= '0;
                end
                OP_GAP: begin
                    r_gap <= w_gap_sum[GAP_W] ? '1 : w_gap_sum[GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Rounding pipeline, step results and dividers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_dist[0] <= i_in.dist_axis0;
                r_dist[1] <= i_in.dist_axis1;
                r_dist[2] <= i_in.dist_axis2;
            end
            OP_LOAD: begin
                if (i_cmd.time_sel) begin
                    r_v <= {{(V_W - SLICE_W - TIME_SHIFT){1'b0}}, r_slice,
                            {TIME_SHIFT{1'b0}}};
                end else begin
                    r_v <= {{(V_W - PROD_W){w_prod[PROD_W-1]}}, w_prod};
                end
            end
            OP_ADD: begin
                r_v <= r_v + w_addend;
            end
            OP_ABS: begin
                r_neg <= r_v[V_W-1];
                r_mag <= r_v[V_W-1] ? -r_v : r_v;
            end
            OP_QUOT: begin
                r_q <= w_sum_q[V_W-1:SCALE_FRAC];
            end
            OP_SIGN: begin
                r_s <= r_neg ? -$signed(r_q) : $signed(r_q);
            end
            OP_COMMIT: begin
                if (i_cmd.time_sel) begin
                    // A slice that rounds below zero counts as no cycles.
                    r_cycles <= r_s[Q_W-1] ? '0 : $unsigned(r_s);
                end else if (w_zero) begin
                    r_steps[i_cmd.idx] <= '0;
                    r_dir[i_cmd.idx]   <= 1'b0;
                end else begin
                    r_steps[i_cmd.idx] <= r_q[STEP_W-1:0];
                    r_dir[i_cmd.idx]   <= r_neg && (r_q != '0);
                end
            end
            OP_DIV_START: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_dq[a]  <= w_total;
                    r_rem[a] <= '0;
                end
            end
            OP_DIV_STEP: begin
                // Restoring division, one quotient bit per lane per cycle.
                for (int a = 0; a < NUM_AXES; a++) begin
                    if ({r_rem[a], r_dq[a][TOTAL_W-1]} >= {1'b0, r_steps[a]}) begin
                        r_rem[a] <= STEP_W'({r_rem[a], r_dq[a][TOTAL_W-1]} -
                                            {1'b0, r_steps[a]});
                        r_dq[a]  <= {r_dq[a][TOTAL_W-2:0], 1'b1};
                    end else begin
                        r_rem[a] <= {r_rem[a][STEP_W-2:0], r_dq[a][TOTAL_W-1]};
                        r_dq[a]  <= {r_dq[a][TOTAL_W-2:0], 1'b0};
                    end
                end
            end
            OP_EMIT: begin
                r_out.axis_id     <= AXIS_ID_W'(i_cmd.idx);
                r_out.step_count  <= r_steps[i_cmd.idx];
                r_out.direction   <= r_dir[i_cmd.idx];
                r_out.step_period <= w_period;
                r_out.position    <= r_pos[i_cmd.idx];
                r_out.last_axis   <= (i_cmd.idx == LAST_IDX);
            end
            default: begin
            end
        endcase
    end

    // Output transaction valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.any_step = r_any;

endmodule

[design/multi_axis_slice_step_quantizer.sv]
// ============================================================================
// multi_axis_slice_step_quantizer
// Converts per-slice axis moves to step counts and step periods with
// error diffusion of the rounding residuals.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one path sample per
//   transaction. Output channel (o_out_valid / i_out_ready / o_out) returns
//   one result per axis in axis order, last_axis set on the final one. A
//   sample that steps no axis returns nothing and adds its cycles to the gap.
//   Configuration writes (i_cfg_valid / o_cfg_ready) are always taken. The
//   user must issue them only while the block is idle; it is not enforced.
// Sequence:
//   The four rounding passes (three axes and the slice length) each go
//   through the load, add, abs, quotient, sign and commit steps of the
//   shared rounding unit, then the per-axis restoring dividers run, one
//   quotient bit per cycle. A sample with no steps skips the dividers. A
//   new sample is accepted only after the last result of the one before
//   it has been loaded into the output register.
// Reset and stalls:
//   Synchronous reset clears residuals, positions, gap count and restores
//   the default scales. A stalled receiver holds the result in the output
//   register; the sequencer waits, and the next sample is accepted while the
//   last result is still pending.
// ============================================================================
module multi_axis_slice_step_quantizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  massq_pkg::t_in_item               i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output massq_pkg::t_out_item              o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [massq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [massq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import massq_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    massq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    massq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[design/massq_checker.sv]
// ============================================================================
// massq_checker
// Port-level checks for the slice step quantizer, bound to the top level.
// ============================================================================
`include "multi_axis_slice_step_quantizer_defines.svh"

module massq_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  massq_pkg::t_out_item  o_out
);
    import massq_pkg::*;

    logic w_out_stall;
    logic w_in_take;
    logic w_last_ok;
    logic w_idle_ok;

    // Handshake and payload conditions used by the checks below.
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_last_ok   = (o_out.last_axis == (o_out.axis_id == LAST_AXIS_ID));
    assign w_idle_ok   = (o_out.step_count != '0) ||
                         (!o_out.direction && (o_out.step_period == '0));

    // A pending result stays offered until taken.
    `MASSQ_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_out_valid, "result dropped")

    // A stalled result keeps its payload.
    `MASSQ_ASSERT(a_out_stable, i_clk, i_rst_n, w_out_stall |=> $stable(o_out), "result changed")

    // One sample at a time: the input closes right after a transaction.
    `MASSQ_ASSERT(a_in_one, i_clk, i_rst_n, w_in_take |=> !o_in_ready, "input taken twice")

    // The final result of a sample carries the last axis number.
    `MASSQ_ASSERT(a_last_axis, i_clk, i_rst_n, o_out_valid |-> w_last_ok, "bad last flag")

    // An axis without steps reports no direction and no period.
    `MASSQ_ASSERT(a_idle_axis, i_clk, i_rst_n, o_out_valid |-> w_idle_ok, "idle axis result")

endmodule

bind multi_axis_slice_step_quantizer massq_checker u_massq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
